/* design/lci_pkg.sv */
package lci_pkg;

  localparam int COORD_W = 32;
  localparam int DELTA_W = COORD_W + 1;
  localparam int RAD_W = 31;
  localparam int PROD_W = COORD_W + DELTA_W;
  localparam int SQ_W = 2 * DELTA_W;
  localparam int RR_W = 2 * RAD_W;
  localparam int A_W = SQ_W;
  localparam int P_W = SQ_W;
  localparam int HALF_W = 32;
  localparam int DISC_W = 128;
  localparam int ROOT_W = DISC_W / 2;
  localparam int REM_W = ROOT_W + 2;
  localparam int NUM_W = P_W + 1;
  localparam int MAG_W = P_W;
  localparam int SPLIT_W = 33;
  localparam int RSPLIT_W = 31;
  localparam int DMAG_W = COORD_W;
  localparam int PP_W = SPLIT_W + DMAG_W;
  localparam int DIVN_W = 100;
  localparam int QUO_W = 34;
  localparam int SUM_W = QUO_W + 2;
  localparam int LANES = 4;

  localparam int FRONT_STAGES = 6;
  localparam int MID_STAGES = 5;
  localparam int PIPE_LAT = FRONT_STAGES + ROOT_W + MID_STAGES + QUO_W + 1;

  localparam int LANE_PX = 0;
  localparam int LANE_PY = 1;
  localparam int LANE_MX = 2;
  localparam int LANE_MY = 3;

  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_TANGENT = 2'd1;
  localparam logic [1:0] CNT_SECANT = 2'd2;

  localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef struct packed {
    logic deg;
    logic nocross;
    logic tangent;
    logic signed [P_W-1:0] p;
    logic [A_W-1:0] a;
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
  } lci_geo_t;

  typedef struct packed {
    logic deg;
    logic nocross;
    logic tangent;
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic [LANES-1:0] neg;
    logic [LANES-1:0] pre;
  } lci_tail_t;

endpackage

/* design/lci_sqrt_cell.sv */
module lci_sqrt_cell import lci_pkg::*; (
  input  logic              clk,
  input  logic [REM_W-1:0]  rem_in,
  input  logic [ROOT_W-1:0] root_in,
  input  logic [DISC_W-1:0] disc_in,
  output logic [REM_W-1:0]  rem_out,
  output logic [ROOT_W-1:0] root_out,
  output logic [DISC_W-1:0] disc_out
);

  logic [REM_W+1:0] cur;
  logic [REM_W+1:0] trial;
  logic [REM_W+1:0] diff;
  logic             fits;

  // one root bit per cell: bring down two radicand bits, try 4*root+1
  always_comb begin
    cur   = {rem_in, disc_in[DISC_W-1 -: 2]};
    trial = {2'b00, root_in, 2'b01};
    diff  = cur - trial;
    fits  = (cur >= trial);
  end

  always_ff @(posedge clk) begin
    rem_out  <= fits ? diff[REM_W-1:0] : cur[REM_W-1:0];
    root_out <= {root_in[ROOT_W-2:0], fits};
    disc_out <= {disc_in[DISC_W-3:0], 2'b00};
  end

endmodule

/* design/lci_div_cell.sv */
module lci_div_cell import lci_pkg::*; (
  input  logic                        clk,
  input  logic [A_W-1:0]              a_in,
  input  logic [LANES-1:0][A_W-1:0]   rem_in,
  input  logic [LANES-1:0][QUO_W-1:0] low_in,
  input  logic [LANES-1:0][QUO_W-1:0] quo_in,
  output logic [A_W-1:0]              a_out,
  output logic [LANES-1:0][A_W-1:0]   rem_out,
  output logic [LANES-1:0][QUO_W-1:0] low_out,
  output logic [LANES-1:0][QUO_W-1:0] quo_out
);

  logic [LANES-1:0][A_W:0] cur;
  logic [LANES-1:0][A_W:0] diff;
  logic [LANES-1:0]        ge;

  // restoring division, one quotient bit per cell, four lanes share the divisor
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      cur[l]  = {rem_in[l], low_in[l][QUO_W-1]};
      diff[l] = cur[l] - {1'b0, a_in};
      ge[l]   = (cur[l] >= {1'b0, a_in});
    end
  end

  always_ff @(posedge clk) begin
    a_out <= a_in;
    for (int l = 0; l < LANES; l++) begin
      rem_out[l] <= ge[l] ? diff[l][A_W-1:0] : cur[l][A_W-1:0];
      low_out[l] <= {low_in[l][QUO_W-2:0], 1'b0};
      quo_out[l] <= {quo_in[l][QUO_W-2:0], ge[l]};
    end
  end

endmodule

/* design/line_circle_intersection.sv */
// Line / circle intersection, circle centered at the origin.
// Command channel: a transaction is taken on a rising edge with start high
// and busy low. busy is high only during reset, so one query can enter every
// cycle. Each query returns exactly one result, marked by a one-cycle done
// strobe, in query order; the receiver cannot stall, so results are never
// held and there is no back pressure.
// Throughput is one query per cycle.
// The latency is set by the square-root row (64 cells, one root bit each)
// and the divider row (34 cells, one quotient bit each, four lanes), plus
// twelve stages of split multipliers, wide adds and output saturation.
// Coordinates are raw fixed point integers; the scale cancels, so results
// do not depend on the number of fraction bits.
// Reset (rst, synchronous) clears the pipeline valid bits; no result is
// produced for a query still in flight at reset.
// Coincident points give count 0 with degenerate set; missed circles give
// count 0; out-of-range coordinates saturate and set overflow.
module line_circle_intersection import lci_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [COORD_W-1:0] first_x,
  input  logic signed [COORD_W-1:0] first_y,
  input  logic signed [COORD_W-1:0] second_x,
  input  logic signed [COORD_W-1:0] second_y,
  input  logic [RAD_W-1:0]          radius,
  output logic                      done,
  output logic [1:0]                crossing_count,
  output logic signed [COORD_W-1:0] plus_x,
  output logic signed [COORD_W-1:0] plus_y,
  output logic signed [COORD_W-1:0] minus_x,
  output logic signed [COORD_W-1:0] minus_y,
  output logic                      degenerate,
  output logic                      overflow
);

  logic                accept;
  logic [PIPE_LAT-1:0] vld;

  assign busy   = rst;
  assign accept = start && !busy;
  assign done   = vld[PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PIPE_LAT-2:0], accept};
    end
  end

  // stage 1: capture, deltas
  logic signed [COORD_W-1:0] x1_1, y1_1;
  logic signed [DELTA_W-1:0] dx_1, dy_1;
  logic [RAD_W-1:0]          r_1;

  always_ff @(posedge clk) begin
    x1_1 <= first_x;
    y1_1 <= first_y;
    dx_1 <= DELTA_W'(second_x) - DELTA_W'(first_x);
    dy_1 <= DELTA_W'(second_y) - DELTA_W'(first_y);
    r_1  <= radius;
  end

  // stage 2: narrow products
  logic signed [COORD_W-1:0] x1_2, y1_2;
  logic signed [DELTA_W-1:0] dx_2, dy_2;
  logic signed [SQ_W-1:0]    ddx_2, ddy_2;
  logic signed [PROD_W-1:0]  x1dx_2, y1dy_2, x1dy_2, y1dx_2;
  logic [RR_W-1:0]           rr_2;
  logic                      deg_2;

  always_ff @(posedge clk) begin
    x1_2   <= x1_1;
    y1_2   <= y1_1;
    dx_2   <= dx_1;
    dy_2   <= dy_1;
    ddx_2  <= dx_1 * dx_1;
    ddy_2  <= dy_1 * dy_1;
    x1dx_2 <= x1_1 * dx_1;
    y1dy_2 <= y1_1 * dy_1;
    x1dy_2 <= x1_1 * dy_1;
    y1dx_2 <= y1_1 * dx_1;
    rr_2   <= r_1 * r_1;
    deg_2  <= (dx_1 == '0) && (dy_1 == '0);
  end

  // stage 3: a, p, |k|
  lci_geo_t              g3, g3_next;
  logic signed [P_W-1:0] k_w;
  logic [P_W-1:0]        kabs_w;
  logic [2*HALF_W-1:0]   kmag_3;
  logic                  kbig_3;
  logic [RR_W-1:0]       rr_3;

  always_comb begin
    g3_next         = '0;
    g3_next.deg     = deg_2;
    g3_next.p       = P_W'(x1dx_2) + P_W'(y1dy_2);
    g3_next.a       = $unsigned(ddx_2) + $unsigned(ddy_2);
    g3_next.x1      = x1_2;
    g3_next.y1      = y1_2;
    g3_next.dx      = dx_2;
    g3_next.dy      = dy_2;
    k_w             = P_W'(x1dy_2) - P_W'(y1dx_2);
    kabs_w          = k_w[P_W-1] ? -k_w : k_w;
  end

  always_ff @(posedge clk) begin
    g3     <= g3_next;
    kmag_3 <= kabs_w[2*HALF_W-1:0];
    kbig_3 <= |kabs_w[P_W-1:2*HALF_W];
    rr_3   <= rr_2;
  end

  // stage 4: partial products of k^2 and a*r^2
  lci_geo_t                      g4;
  logic [2*HALF_W-1:0]           kll_4, klh_4, khh_4;
  logic [SPLIT_W+RSPLIT_W-1:0]   ar00_4, ar01_4, ar10_4, ar11_4;
  logic                          kbig_4;

  always_ff @(posedge clk) begin
    g4     <= g3;
    kbig_4 <= kbig_3;
    kll_4  <= kmag_3[HALF_W-1:0] * kmag_3[HALF_W-1:0];
    klh_4  <= kmag_3[HALF_W-1:0] * kmag_3[2*HALF_W-1:HALF_W];
    khh_4  <= kmag_3[2*HALF_W-1:HALF_W] * kmag_3[2*HALF_W-1:HALF_W];
    ar00_4 <= g3.a[SPLIT_W-1:0] * rr_3[RSPLIT_W-1:0];
    ar01_4 <= g3.a[SPLIT_W-1:0] * rr_3[RR_W-1:RSPLIT_W];
    ar10_4 <= g3.a[A_W-1:SPLIT_W] * rr_3[RSPLIT_W-1:0];
    ar11_4 <= g3.a[A_W-1:SPLIT_W] * rr_3[RR_W-1:RSPLIT_W];
  end

  // stage 5: sum partials
  lci_geo_t            g5;
  logic [DISC_W-1:0]   k2_5, ra_5;
  logic                kbig_5;

  always_ff @(posedge clk) begin
    g5     <= g4;
    kbig_5 <= kbig_4;
    k2_5   <= (DISC_W'(khh_4) << (2*HALF_W)) + (DISC_W'(klh_4) << (HALF_W+1))
              + DISC_W'(kll_4);
    ra_5   <= (DISC_W'(ar11_4) << (SPLIT_W+RSPLIT_W)) + (DISC_W'(ar10_4) << SPLIT_W)
              + (DISC_W'(ar01_4) << RSPLIT_W) + DISC_W'(ar00_4);
  end

  // stage 6: discriminant
  lci_geo_t          g6, g6_next;
  logic [DISC_W-1:0] disc_6;

  always_comb begin
    g6_next         = g5;
    g6_next.nocross = kbig_5 || (k2_5 > ra_5);
    g6_next.tangent = (k2_5 == ra_5);
  end

  always_ff @(posedge clk) begin
    g6     <= g6_next;
    disc_6 <= ra_5 - k2_5;
  end

  // square-root row
  logic [ROOT_W:0][REM_W-1:0]  sq_rem;
  logic [ROOT_W:0][ROOT_W-1:0] sq_root;
  logic [ROOT_W:0][DISC_W-1:0] sq_disc;
  lci_geo_t                    geo_d [ROOT_W];

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_disc[0] = disc_6;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
    lci_sqrt_cell u_cell (
      .clk      (clk),
      .rem_in   (sq_rem[i]),
      .root_in  (sq_root[i]),
      .disc_in  (sq_disc[i]),
      .rem_out  (sq_rem[i+1]),
      .root_out (sq_root[i+1]),
      .disc_out (sq_disc[i+1])
    );
  end

  always_ff @(posedge clk) begin
    geo_d[0] <= g6;
    for (int i = 1; i < ROOT_W; i++) begin
      geo_d[i] <= geo_d[i-1];
    end
  end

  // stage 7: -p +/- s
  lci_geo_t                g7;
  logic signed [NUM_W-1:0] np_7, nm_7;

  always_ff @(posedge clk) begin
    g7   <= geo_d[ROOT_W-1];
    np_7 <= NUM_W'(sq_root[ROOT_W]) - NUM_W'(geo_d[ROOT_W-1].p);
    nm_7 <= NUM_W'(0) - NUM_W'(geo_d[ROOT_W-1].p) - NUM_W'(sq_root[ROOT_W]);
  end

  // stage 8: magnitudes and signs per lane
  lci_geo_t                        g8;
  logic [LANES-1:0][MAG_W-1:0]     mag_8;
  logic [LANES-1:0][DMAG_W-1:0]    dm_8;
  logic [LANES-1:0]                sg_8;
  logic [NUM_W-1:0]                npa_w, nma_w;
  logic [DELTA_W-1:0]              dxa_w, dya_w;

  always_comb begin
    npa_w = np_7[NUM_W-1] ? -np_7 : np_7;
    nma_w = nm_7[NUM_W-1] ? -nm_7 : nm_7;
    dxa_w = g7.dx[DELTA_W-1] ? -g7.dx : g7.dx;
    dya_w = g7.dy[DELTA_W-1] ? -g7.dy : g7.dy;
  end

  always_ff @(posedge clk) begin
    g8             <= g7;
    mag_8[LANE_PX] <= npa_w[MAG_W-1:0];
    mag_8[LANE_PY] <= npa_w[MAG_W-1:0];
    mag_8[LANE_MX] <= nma_w[MAG_W-1:0];
    mag_8[LANE_MY] <= nma_w[MAG_W-1:0];
    dm_8[LANE_PX]  <= dxa_w[DMAG_W-1:0];
    dm_8[LANE_PY]  <= dya_w[DMAG_W-1:0];
    dm_8[LANE_MX]  <= dxa_w[DMAG_W-1:0];
    dm_8[LANE_MY]  <= dya_w[DMAG_W-1:0];
    sg_8[LANE_PX]  <= np_7[NUM_W-1] ^ g7.dx[DELTA_W-1];
    sg_8[LANE_PY]  <= np_7[NUM_W-1] ^ g7.dy[DELTA_W-1];
    sg_8[LANE_MX]  <= nm_7[NUM_W-1] ^ g7.dx[DELTA_W-1];
    sg_8[LANE_MY]  <= nm_7[NUM_W-1] ^ g7.dy[DELTA_W-1];
  end

  // stage 9: split products
  lci_geo_t                  g9;
  logic [LANES-1:0][PP_W-1:0] pp0_9, pp1_9;
  logic [LANES-1:0]          neg_9;

  always_ff @(posedge clk) begin
    g9 <= g8;
    for (int l = 0; l < LANES; l++) begin
      pp0_9[l] <= mag_8[l][SPLIT_W-1:0] * dm_8[l];
      pp1_9[l] <= mag_8[l][MAG_W-1:SPLIT_W] * dm_8[l];
      neg_9[l] <= sg_8[l] && (mag_8[l] != '0) && (dm_8[l] != '0);
    end
  end

  // stage 10: |num*delta| + a/2
  lci_geo_t                     g10;
  logic [LANES-1:0][DIVN_W-1:0] n_10;
  logic [LANES-1:0]             neg_10;

  always_ff @(posedge clk) begin
    g10    <= g9;
    neg_10 <= neg_9;
    for (int l = 0; l < LANES; l++) begin
      n_10[l] <= (DIVN_W'(pp1_9[l]) << SPLIT_W) + DIVN_W'(pp0_9[l])
                 + DIVN_W'(g9.a >> 1);
    end
  end

  // stage 11: divider entry; quotient beyond QUO_W bits is flagged up front
  lci_tail_t                      tail_11;
  logic [A_W-1:0]                 a_11;
  logic [LANES-1:0][A_W-1:0]      rem_11;
  logic [LANES-1:0][QUO_W-1:0]    low_11;

  always_ff @(posedge clk) begin
    a_11            <= g10.a;
    tail_11.deg     <= g10.deg;
    tail_11.nocross <= g10.nocross;
    tail_11.tangent <= g10.tangent;
    tail_11.x1      <= g10.x1;
    tail_11.y1      <= g10.y1;
    tail_11.neg     <= neg_10;
    for (int l = 0; l < LANES; l++) begin
      rem_11[l]      <= n_10[l][DIVN_W-1:QUO_W];
      low_11[l]      <= n_10[l][QUO_W-1:0];
      tail_11.pre[l] <= (n_10[l][DIVN_W-1:QUO_W] >= g10.a);
    end
  end

  // divider row
  logic [QUO_W:0][A_W-1:0]              dv_a;
  logic [QUO_W:0][LANES-1:0][A_W-1:0]   dv_rem;
  logic [QUO_W:0][LANES-1:0][QUO_W-1:0] dv_low;
  logic [QUO_W:0][LANES-1:0][QUO_W-1:0] dv_quo;
  lci_tail_t                            tail_d [QUO_W];

  assign dv_a[0]   = a_11;
  assign dv_rem[0] = rem_11;
  assign dv_low[0] = low_11;
  assign dv_quo[0] = '0;

  for (genvar i = 0; i < QUO_W; i++) begin : g_div
    lci_div_cell u_cell (
      .clk     (clk),
      .a_in    (dv_a[i]),
      .rem_in  (dv_rem[i]),
      .low_in  (dv_low[i]),
      .quo_in  (dv_quo[i]),
      .a_out   (dv_a[i+1]),
      .rem_out (dv_rem[i+1]),
      .low_out (dv_low[i+1]),
      .quo_out (dv_quo[i+1])
    );
  end

  always_ff @(posedge clk) begin
    tail_d[0] <= tail_11;
    for (int i = 1; i < QUO_W; i++) begin
      tail_d[i] <= tail_d[i-1];
    end
  end

  // stage 12: sign, offset, saturate
  lci_tail_t                        tl;
  logic [LANES-1:0][COORD_W-1:0]    res_w;
  logic [LANES-1:0]                 ovf_w;
  logic [LANES-1:0][SUM_W-1:0]      sum_w;
  logic [LANES-1:0]                 inrange_w;
  logic [LANES-1:0]                 satneg_w;

  assign tl = tail_d[QUO_W-1];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      sum_w[l] = (tl.neg[l] ? -SUM_W'(dv_quo[QUO_W][l]) : SUM_W'(dv_quo[QUO_W][l]))
                 + ((l == LANE_PX || l == LANE_MX) ? SUM_W'(tl.x1) : SUM_W'(tl.y1));
      inrange_w[l] = (sum_w[l][SUM_W-1:COORD_W-1] == '0)
                     || (sum_w[l][SUM_W-1:COORD_W-1] == '1);
      satneg_w[l]  = tl.pre[l] ? tl.neg[l] : sum_w[l][SUM_W-1];
      ovf_w[l]     = tl.pre[l] || !inrange_w[l];
      res_w[l]     = ovf_w[l] ? (satneg_w[l] ? COORD_MIN : COORD_MAX)
                              : sum_w[l][COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (tl.deg || tl.nocross) begin
      crossing_count <= CNT_NONE;
      plus_x         <= '0;
      plus_y         <= '0;
      minus_x        <= '0;
      minus_y        <= '0;
      overflow       <= 1'b0;
    end else begin
      crossing_count <= tl.tangent ? CNT_TANGENT : CNT_SECANT;
      plus_x         <= res_w[LANE_PX];
      plus_y         <= res_w[LANE_PY];
      minus_x        <= res_w[LANE_MX];
      minus_y        <= res_w[LANE_MY];
      overflow       <= |ovf_w;
    end
    degenerate <= tl.deg;
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##PIPE_LAT done)
    else $error("result strobe out of step with accepted transactions");

  a_degen: assert property (@(posedge clk) disable iff (rst)
    done && degenerate |-> crossing_count == CNT_NONE && !overflow)
    else $error("degenerate transaction reported crossings");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    done && crossing_count == CNT_NONE |->
      plus_x == '0 && plus_y == '0 && minus_x == '0 && minus_y == '0 && !overflow)
    else $error("no-crossing result carries coordinates");

  a_tangent: assert property (@(posedge clk) disable iff (rst)
    done && crossing_count == CNT_TANGENT |-> plus_x == minus_x && plus_y == minus_y)
    else $error("tangent result has two distinct points");

endmodule

/* sim/line_circle_intersection_tb.sv */
module line_circle_intersection_tb;
  import lci_pkg::*;

  typedef struct {
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic signed [COORD_W-1:0] x2;
    logic signed [COORD_W-1:0] y2;
    logic [RAD_W-1:0]          r;
    bit                        drain;
  } query_t;

  typedef struct {
    logic [1:0]                cnt;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] mx;
    logic signed [COORD_W-1:0] my;
    logic                      deg;
    logic                      ovf;
  } crossing_t;

  localparam int STALL_LIMIT = 4 * PIPE_LAT + 200;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic signed [COORD_W-1:0] first_x, first_y, second_x, second_y;
  logic [RAD_W-1:0] radius;
  logic done;
  logic [1:0] crossing_count;
  logic signed [COORD_W-1:0] plus_x, plus_y, minus_x, minus_y;
  logic degenerate, overflow;

  query_t    pending_q[$];
  crossing_t crossings_q[$];
  bit        took;
  int        gap;
  int        idle_cycles;
  int        errors;
  int        issued;

  line_circle_intersection dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .first_x(first_x), .first_y(first_y), .second_x(second_x), .second_y(second_y),
    .radius(radius), .done(done), .crossing_count(crossing_count),
    .plus_x(plus_x), .plus_y(plus_y), .minus_x(minus_x), .minus_y(minus_y),
    .degenerate(degenerate), .overflow(overflow)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic signed [255:0] isqrt(logic signed [255:0] x);
    logic signed [255:0] res, b, trial;
    res = 0;
    b = 256'sd1 <<< 126;
    while (b != 0 && b > x) b = b >>> 2;
    while (b != 0) begin
      trial = res + b;
      if (x >= trial) begin
        x = x - trial;
        res = (res >>> 1) + b;
      end else begin
        res = res >>> 1;
      end
      b = b >>> 2;
    end
    return res;
  endfunction

  // rounded num*delta/a (ties away from zero) plus base, saturated to 32 bits
  function automatic logic signed [COORD_W-1:0] place(logic signed [255:0] num,
      logic signed [255:0] delta, logic signed [255:0] a, logic signed [255:0] base,
      inout logic ovf);
    logic signed [255:0] prod, mag, quo, v;
    prod = num * delta;
    mag = (prod < 0) ? -prod : prod;
    quo = (mag + (a >>> 1)) / a;
    if (prod < 0) quo = -quo;
    v = quo + base;
    if (v > 256'sd2147483647) begin
      ovf = 1'b1;
      return COORD_MAX;
    end
    if (v < -256'sd2147483648) begin
      ovf = 1'b1;
      return COORD_MIN;
    end
    return v[COORD_W-1:0];
  endfunction

  function automatic crossing_t predict_crossing(query_t q);
    logic signed [255:0] x1, y1, dx, dy, a, p, k, k2, ra, rr, disc, s;
    crossing_t c;
    logic ovf;
    c = '{CNT_NONE, 0, 0, 0, 0, 1'b0, 1'b0};
    ovf = 1'b0;
    x1 = q.x1;
    y1 = q.y1;
    dx = $signed({{224{q.x2[COORD_W-1]}}, q.x2}) - x1;
    dy = $signed({{224{q.y2[COORD_W-1]}}, q.y2}) - y1;
    rr = $signed({225'd0, q.r});
    if (dx == 0 && dy == 0) begin
      c.deg = 1'b1;
      return c;
    end
    a = dx * dx + dy * dy;
    p = x1 * dx + y1 * dy;
    k = x1 * dy - y1 * dx;
    if (k < 0) k = -k;
    if (k >= (256'sd1 <<< 64)) return c;
    k2 = k * k;
    ra = a * rr * rr;
    if (k2 > ra) return c;
    disc = ra - k2;
    s = isqrt(disc);
    c.cnt = (disc == 0) ? CNT_TANGENT : CNT_SECANT;
    c.px = place(s - p, dx, a, x1, ovf);
    c.py = place(s - p, dy, a, y1, ovf);
    c.mx = place(-p - s, dx, a, x1, ovf);
    c.my = place(-p - s, dy, a, y1, ovf);
    c.ovf = ovf;
    return c;
  endfunction

  function automatic query_t mk(int x1, int y1, int x2, int y2, int unsigned r);
    query_t q;
    q.x1 = x1; q.y1 = y1; q.x2 = x2; q.y2 = y2;
    q.r = r[RAD_W-1:0];
    q.drain = 1'b0;
    return q;
  endfunction

  function automatic int near(int unsigned span);
    return int'($urandom_range(2 * span, 0)) - int'(span);
  endfunction

  // driver: inputs change on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap = 0;
    end else begin
      if (took) begin
        void'(pending_q.pop_front());
        gap = (issued % 400 < 100) ? 0 : $urandom_range(3, 0);
      end
      if (gap > 0) begin
        gap--;
        start <= 1'b0;
      end else if (pending_q.size() > 0 &&
                   !(pending_q[0].drain && crossings_q.size() > 0)) begin
        start    <= 1'b1;
        first_x  <= pending_q[0].x1;
        first_y  <= pending_q[0].y1;
        second_x <= pending_q[0].x2;
        second_y <= pending_q[0].y2;
        radius   <= pending_q[0].r;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: transaction accept, result check and watchdog on the rising edge
  always @(posedge clk) begin
    crossing_t want;
    took = 1'b0;
    if (!rst) begin
      idle_cycles++;
      if (start && !busy) begin
        crossings_q.push_back(predict_crossing(mk(first_x, first_y, second_x,
                                                  second_y, radius)));
        took = 1'b1;
        issued++;
        idle_cycles = 0;
      end
      if (done) begin
        idle_cycles = 0;
        if (crossings_q.size() == 0) begin
          $display("%0t: unexpected result count=%0d", $time, crossing_count);
          errors++;
        end else begin
          want = crossings_q.pop_front();
          if (want.cnt !== crossing_count || want.px !== plus_x || want.py !== plus_y ||
              want.mx !== minus_x || want.my !== minus_y ||
              want.deg !== degenerate || want.ovf !== overflow) begin
            $display("%0t: mismatch expected cnt=%0d p=(%0d,%0d) m=(%0d,%0d) deg=%b ovf=%b",
                     $time, want.cnt, want.px, want.py, want.mx, want.my, want.deg, want.ovf);
            $display("%0t:          actual cnt=%0d p=(%0d,%0d) m=(%0d,%0d) deg=%b ovf=%b",
                     $time, crossing_count, plus_x, plus_y, minus_x, minus_y,
                     degenerate, overflow);
            errors++;
          end
        end
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("line_circle_intersection_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    query_t q;
    int sel, r, x, y;
    rst = 1'b1;
    start = 1'b0;
    first_x = 0; first_y = 0; second_x = 0; second_y = 0; radius = 0;
    took = 1'b0;
    idle_cycles = 0;
    errors = 0;
    issued = 0;

    // directed transactions
    pending_q.push_back(mk(5, 7, 5, 7, 100));                       // coincident points
    pending_q.push_back(mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 0));
    pending_q.push_back(mk(-100, 50, 100, 50, 50));                 // tangent
    pending_q.push_back(mk(-100, 50, 100, 50, 49));                 // miss by one
    pending_q.push_back(mk(-100, 50, 100, 50, 51));                 // secant
    pending_q.push_back(mk(0, 0, 3, 4, 10));                        // through origin
    pending_q.push_back(mk(1000, 1000, 1001, 1000, 0));             // zero radius miss
    pending_q.push_back(mk(0, 0, 1, 0, 0));                         // zero radius tangent
    pending_q.push_back(mk(0, 0, 1, 1, 32'h7FFFFFFF));             // large radius, points stay in range
    pending_q.push_back(mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                           32'h7FFFFFFF));
    pending_q.push_back(mk(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                           32'h7FFFFFFF));
    pending_q.push_back(mk(32'h7FFFFFFF, 0, 32'h80000000, 0, 32'h40000000));
    pending_q.push_back(mk(32'h80000000, 32'h80000000, 32'h80000001, 32'h80000000, 5));
    pending_q.push_back(mk(-1, -1, 0, 0, 1));
    pending_q.push_back(mk(0, 32'h7FFFFFFF, 1, 32'h7FFFFFFF, 32'h7FFFFFFF)); // far tangent
    pending_q.push_back(mk(-3, 1, 3, 2, 3));                        // rounding of small values
    pending_q.push_back(mk(1, -7, -2, 5, 6));

    // random transactions: mostly lines close enough to hit, some wild
    for (int i = 0; i < 1600; i++) begin
      sel = $urandom_range(9, 0);
      if (sel < 2) begin
        q = mk($urandom, $urandom, $urandom, $urandom, $urandom);
      end else if (sel == 2) begin
        x = $urandom; y = $urandom;
        q = mk(x, y, ($urandom_range(1, 0) != 0) ? x : $urandom,
               ($urandom_range(1, 0) != 0) ? y : y + near(2), $urandom);
      end else begin
        r = $urandom_range(1 << (4 + 3 * (sel - 3)), 0);
        q = mk(near(2 * r + 2), near(2 * r + 2), near(2 * r + 2), near(2 * r + 2), r);
        if (sel == 9) q.y2 = q.y1 + near(1);
      end
      q.drain = (i == 700 || i == 1300);
      pending_q.push_back(q);
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    wait (pending_q.size() == 0 && crossings_q.size() == 0);
    repeat (PIPE_LAT + 20) @(posedge clk);
    if (errors == 0) begin
      $display("line_circle_intersection_tb OK");
    end else begin
      $display("line_circle_intersection_tb NOT OK");
    end
    $finish;
  end

endmodule
